// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sh24 assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sh24 assertion failed");

`endif

// ===== hw/rtl/sh24_pkg.sv =====
// Shared types, constants, round function and microcode table for SipHash-2-4.
`default_nettype none

package sh24_pkg;

    localparam int WORD_W = 64;
    localparam int LEN_W  = 8;
    localparam int CNT_W  = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int PC_W   = 4;

    localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] KEY_LOW_RESET  = 64'h0706050403020100;
    localparam logic [WORD_W-1:0] KEY_HIGH_RESET = 64'h0f0e0d0c0b0a0908;
    localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

    typedef logic [PC_W-1:0] pc_t;

    // program steps
    localparam pc_t STEP_ENTRY = 4'd0;  // wait for a beat, first half of compression
    localparam pc_t STEP_W1    = 4'd1;  // second half, plain word
    localparam pc_t STEP_F1    = 4'd2;  // second half, full last word
    localparam pc_t STEP_F2    = 4'd3;  // first half, length-only final block
    localparam pc_t STEP_T1    = 4'd4;  // second half of final block, v2 ^= 0xff
    localparam pc_t STEP_R1    = 4'd5;
    localparam pc_t STEP_R2    = 4'd6;
    localparam pc_t STEP_R3    = 4'd7;
    localparam pc_t STEP_R4    = 4'd8;
    localparam pc_t STEP_EMIT  = 4'd9;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ROUND_IN,   // v3 ^= m, then round
        OP_ROUND,      // plain round
        OP_ROUND_OUT,  // round, then v0 ^= m
        OP_ROUND_FIN   // round, then v0 ^= m and v2 ^= 0xff
    } op_t;

    typedef enum logic [1:0] {
        MSEL_IN,       // message from the input beat
        MSEL_HELD,     // message held from the previous step
        MSEL_FINAL     // length-only final block
    } msel_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,   // go to target_a
        COND_DISPATCH, // hold until accept, then branch on last / full
        COND_OUT_FREE  // hold until the output register is free
    } cond_t;

    typedef struct packed {
        op_t   op;
        msel_t msel;
        cond_t cond;
        pc_t   target_a;
        pc_t   target_b;
    } uword_t;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } lanes_t;

    // sequencer -> datapath and top level
    typedef struct packed {
        op_t   op;
        msel_t msel;
        logic  lane_en;
        logic  emit;
        logic  busy;
    } ctrl_t;

    // top -> sequencer
    typedef struct packed {
        logic accept;
        logic last;
        logic full;
        logic out_free;
    } seq_stat_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic lanes_t sip_round(input lanes_t a);
        lanes_t b;
        b = a;
        b.v0 = b.v0 + b.v1;
        b.v1 = rotl(b.v1, 13) ^ b.v0;
        b.v0 = rotl(b.v0, 32);
        b.v2 = b.v2 + b.v3;
        b.v3 = rotl(b.v3, 16) ^ b.v2;
        b.v0 = b.v0 + b.v3;
        b.v3 = rotl(b.v3, 21) ^ b.v0;
        b.v2 = b.v2 + b.v1;
        b.v1 = rotl(b.v1, 17) ^ b.v2;
        b.v2 = rotl(b.v2, 32);
        return b;
    endfunction

    // microcode ROM
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        case (pc)
            STEP_ENTRY: w = '{OP_ROUND_IN,  MSEL_IN,    COND_DISPATCH, STEP_F1,    STEP_T1};
            STEP_W1:    w = '{OP_ROUND_OUT, MSEL_HELD,  COND_ALWAYS,   STEP_ENTRY, STEP_ENTRY};
            STEP_F1:    w = '{OP_ROUND_OUT, MSEL_HELD,  COND_ALWAYS,   STEP_F2,    STEP_F2};
            STEP_F2:    w = '{OP_ROUND_IN,  MSEL_FINAL, COND_ALWAYS,   STEP_T1,    STEP_T1};
            STEP_T1:    w = '{OP_ROUND_FIN, MSEL_HELD,  COND_ALWAYS,   STEP_R1,    STEP_R1};
            STEP_R1:    w = '{OP_ROUND,     MSEL_HELD,  COND_ALWAYS,   STEP_R2,    STEP_R2};
            STEP_R2:    w = '{OP_ROUND,     MSEL_HELD,  COND_ALWAYS,   STEP_R3,    STEP_R3};
            STEP_R3:    w = '{OP_ROUND,     MSEL_HELD,  COND_ALWAYS,   STEP_R4,    STEP_R4};
            STEP_R4:    w = '{OP_ROUND,     MSEL_HELD,  COND_ALWAYS,   STEP_EMIT,  STEP_EMIT};
            STEP_EMIT:  w = '{OP_NOP,       MSEL_HELD,  COND_OUT_FREE, STEP_ENTRY, STEP_ENTRY};
            default:    w = '{OP_NOP,       MSEL_HELD,  COND_ALWAYS,   STEP_ENTRY, STEP_ENTRY};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sh24_sequencer.sv =====
// Microcode sequencer: step counter, ROM fetch and conditional jumps.
`default_nettype none

module sh24_sequencer
    import sh24_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire seq_stat_t stat,
    output ctrl_t          ctrl
);

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t uw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_ENTRY;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        uw = ucode_rom(pc_reg);
        pc_next = uw.target_a;
        case (uw.cond)
            COND_DISPATCH:
            begin
                if (!stat.accept)
                    pc_next = pc_reg;
                else if (!stat.last)
                    pc_next = PC_W'(pc_reg + 1'b1);
                else if (stat.full)
                    pc_next = uw.target_a;
                else
                    pc_next = uw.target_b;
            end
            COND_OUT_FREE:
            begin
                pc_next = stat.out_free ? uw.target_a : pc_reg;
            end
            default:
            begin
                pc_next = uw.target_a;
            end
        endcase

        ctrl.op      = uw.op;
        ctrl.msel    = uw.msel;
        ctrl.lane_en = (uw.cond == COND_DISPATCH) ? stat.accept : 1'b1;
        ctrl.emit    = (uw.cond == COND_OUT_FREE) && stat.out_free;
        ctrl.busy    = (pc_reg != STEP_ENTRY);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sh24_datapath.sv =====
// Lane registers, message and length registers, one shared SipRound unit.
`default_nettype none

module sh24_datapath
    import sh24_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_t             ctrl,
    input  wire logic [WORD_W-1:0] key_low,
    input  wire logic [WORD_W-1:0] key_high,
    input  wire logic [WORD_W-1:0] data_word,
    input  wire logic [CNT_W-1:0]  byte_count,
    input  wire logic              last,
    output logic [WORD_W-1:0]      digest
);

    lanes_t            lanes_reg;
    lanes_t            lanes_next;
    logic [WORD_W-1:0] msg_reg;
    logic [WORD_W-1:0] msg_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              in_msg_reg;

    lanes_t            init_lanes;
    lanes_t            src;
    lanes_t            rnd_in;
    lanes_t            rnd;
    logic              at_entry;
    logic              start;
    logic              short_last;
    logic [LEN_W-1:0]  len_base;
    logic [WORD_W-1:0] tail;
    logic [WORD_W-1:0] m_in;

    always_comb
    begin
        at_entry   = (ctrl.msel == MSEL_IN);
        start      = at_entry && !in_msg_reg;
        short_last = last && !byte_count[CNT_W-1];   // counts of 8 and up act as 8

        init_lanes.v0 = key_low  ^ SIP_C0;
        init_lanes.v1 = key_high ^ SIP_C1;
        init_lanes.v2 = key_low  ^ SIP_C2;
        init_lanes.v3 = key_high ^ SIP_C3;
        src = start ? init_lanes : lanes_reg;

        len_base = start ? '0 : len_reg;
        len_next = len_base + (short_last ? LEN_W'(byte_count[CNT_W-2:0]) : LEN_W'(8));

        for (int i = 0; i < WORD_W / 8; i++)
        begin
            tail[i*8 +: 8] = (i < int'(byte_count[CNT_W-2:0])) ? data_word[i*8 +: 8] : 8'h00;
        end
        m_in = short_last ? {len_next, tail[WORD_W-LEN_W-1:0]} : data_word;

        case (ctrl.msel)
            MSEL_IN:    msg_next = m_in;
            MSEL_FINAL: msg_next = {len_reg, {(WORD_W-LEN_W){1'b0}}};
            default:    msg_next = msg_reg;
        endcase

        // single round unit; v3 takes the message first on a ROUND_IN step
        rnd_in = src;
        if (ctrl.op == OP_ROUND_IN)
        begin
            rnd_in.v3 = src.v3 ^ msg_next;
        end
        rnd = sip_round(rnd_in);

        lanes_next = src;
        case (ctrl.op)
            OP_ROUND_IN:
            begin
                lanes_next = rnd;
            end
            OP_ROUND:
            begin
                lanes_next = rnd;
            end
            OP_ROUND_OUT:
            begin
                lanes_next = rnd;
                lanes_next.v0 = rnd.v0 ^ msg_next;
            end
            OP_ROUND_FIN:
            begin
                lanes_next = rnd;
                lanes_next.v0 = rnd.v0 ^ msg_next;
                lanes_next.v2 = rnd.v2 ^ FINAL_XOR;
            end
            default:
            begin
                lanes_next = src;
            end
        endcase

        digest = lanes_reg.v0 ^ lanes_reg.v1 ^ lanes_reg.v2 ^ lanes_reg.v3;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctrl.lane_en)
        begin
            lanes_reg <= lanes_next;
            msg_reg   <= msg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            in_msg_reg <= 1'b0;
        end
        else if (ctrl.lane_en && at_entry)
        begin
            len_reg    <= len_next;
            in_msg_reg <= !last;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/siphash_2_4.sv =====
// Top level of the SipHash-2-4 engine: key registers, sequencer, datapath, output register.
// Usage
//   Input channel (in_valid / in_stall): one beat per 64-bit little-endian message word
//   with byte_count and last. Only the beat with last set uses byte_count (0..8, larger
//   values act as 8). The first beat after reset or after a last beat starts a new
//   message from the current key.
//   Output channel (out_valid / out_stall): one beat carrying hash_value per message.
//   Config port (cfg_write / cfg_index / cfg_data): index 0 is k0, index 1 is k1,
//   other indexes are dropped. Write only while no message is under way.
// Timing
//   One SipRound per cycle on a single shared round unit, none while waiting for a beat
//   or for the output register; a microcode ROM steps it. A non-last word does its
//   first round in the accept cycle and its second in step W1. A last beat with fewer
//   than 8 bytes then runs T1, R1 to R4 and EMIT; a full last word runs F1 and F2 first.
// Reset
//   rst_n is asynchronous; keys go back to their defaults, no message is open,
//   the output register is empty.
// Back-pressure
//   The hash waits in the output register while out_stall is high; the sequencer
//   holds at its emit step until the register is free, then takes new beats.
`default_nettype none

module siphash_2_4
    import sh24_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // config
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_data,
    // input beats
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [WORD_W-1:0]      data_word,
    input  wire logic [CNT_W-1:0]       byte_count,
    input  wire logic                   last,
    // result beats
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [WORD_W-1:0]           hash_value
);

    logic [WORD_W-1:0] key_low_reg;
    logic [WORD_W-1:0] key_high_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] hash_reg;
    logic [WORD_W-1:0] digest;
    seq_stat_t         stat;
    ctrl_t             ctrl;

    // key registers; reads happen only at the start of a message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= KEY_LOW_RESET;
            key_high_reg <= KEY_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_KEY_LOW)
                key_low_reg <= cfg_data;
            else if (cfg_index == REG_KEY_HIGH)
                key_high_reg <= cfg_data;
        end
    end

    // handshake status into the sequencer
    always_comb
    begin
        stat.accept   = in_valid && !ctrl.busy;
        stat.last     = last;
        stat.full     = byte_count[CNT_W-1];
        stat.out_free = !out_valid_reg || !out_stall;
    end

    assign in_stall = ctrl.busy;

    sh24_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    sh24_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .digest     (digest)
    );

    // output register: loaded at the emit step, cleared when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            hash_reg <= digest;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sh24_checker.sv =====
// Port-level checker for siphash_2_4 and its bind.
`default_nettype none
`include "assert_macros.svh"

module sh24_checker
    import sh24_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              last,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [WORD_W-1:0] hash_value
);

    // held result beat does not move
    `SH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hash_value))
    // after a plain word is accepted, the input is stalled for step W1 only
    `SH_ASSERT_NXT(a_word_two_cycles, in_valid && !in_stall && !last, in_stall ##1 !in_stall)
    // finalization keeps the input side busy
    `SH_ASSERT_NXT(a_last_busy, in_valid && !in_stall && last, in_stall ##1 in_stall)
    // a new result only comes out of the emit step
    `SH_ASSERT_IMP(a_result_from_emit, $rose(out_valid), $past(in_stall))

endmodule

bind siphash_2_4 sh24_checker u_sh24_checker (.*);

`default_nettype wire
